/* rtl/core/lrupr_pkg.sv */
// Shared constants for the LRU page replacement block.
// Fixed field widths and reset values; no dependencies.
package lrupr_pkg;

  localparam int CFG_BITS   = 4;
  localparam int FAULT_BITS = 32;

  localparam logic [CFG_BITS-1:0]   NUM_FRAMES_RESET = CFG_BITS'(8);
  localparam logic [FAULT_BITS-1:0] FAULT_MAX        = {FAULT_BITS{1'b1}};

endpackage

/* rtl/core/lru_page_replacement.sv */
// Requests pass through IDLE, SCAN and DONE; a new request is taken only in IDLE.
// The lookup record walks the cell row one frame per cycle, then DONE applies the
// rank/tag update once the result register is free.
// The result register frees the input side while a result waits for out_ready.
// Reset (rst, synchronous): ranks, fill count and fault count clear, num_frames = 8.
// Uses lrupr_pkg and lrupr_cell.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16,
  localparam int SLOT_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PAGE_BITS-1:0]  page,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [SLOT_BITS-1:0]  frame_slot,
  output logic                  evicted_valid,
  output logic [PAGE_BITS-1:0]  evicted_page,
  output logic [FAULT_BITS-1:0] fault_count
);

  localparam int CNT_BITS = $clog2(MAX_FRAMES + 1);
  localparam int CMP_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
  localparam logic [SLOT_BITS-1:0] CNT_LAST = SLOT_BITS'(MAX_FRAMES - 1);

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [CNT_BITS-1:0]  active;
    logic [CNT_BITS-1:0]  nf;
  } req_t;

  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] slot;
    logic                 all;
    logic [SLOT_BITS-1:0] rank;
    logic [CNT_BITS-1:0]  limit;
    logic                 wr;
  } upd_t;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_BITS-1:0] hit_idx;
    logic [SLOT_BITS-1:0] hit_rank;
    logic [SLOT_BITS-1:0] vict_idx;
    logic [SLOT_BITS-1:0] vict_rank;
    logic [PAGE_BITS-1:0] vict_tag;
  } scan_t;

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

  state_t                state;
  logic [SLOT_BITS-1:0]  scan_cnt;
  req_t                  req;
  logic [CNT_BITS-1:0]   filled;
  logic [FAULT_BITS-1:0] faults;
  logic [CFG_BITS-1:0]   num_frames;

  scan_t                 chain [MAX_FRAMES+1];
  scan_t                 fin;
  upd_t                  upd;
  logic                  out_free;
  logic                  is_fill;
  logic [CMP_BITS-1:0]   cfg_ext;
  logic [CNT_BITS-1:0]   nf_eff;
  logic [CNT_BITS-1:0]   active_eff;
  logic [FAULT_BITS-1:0] faults_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);
  assign out_free  = !out_valid || out_ready;

  // Zero or oversized frame counts clamp to 1..MAX_FRAMES.
  always_comb begin
    cfg_ext = CMP_BITS'(num_frames);
    if (cfg_ext == '0) begin
      nf_eff = CNT_BITS'(1);
    end else if (cfg_ext > CMP_BITS'(MAX_FRAMES)) begin
      nf_eff = CNT_BITS'(MAX_FRAMES);
    end else begin
      nf_eff = CNT_BITS'(cfg_ext);
    end
    active_eff = (filled < nf_eff) ? filled : nf_eff;
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    lrupr_cell #(
      .INDEX      (i),
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .req_t      (req_t),
      .upd_t      (upd_t),
      .scan_t     (scan_t)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .req      (req),
      .upd      (upd),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

  assign fin = chain[MAX_FRAMES];

  always_comb begin
    is_fill   = !fin.hit && (filled < req.nf);
    upd.en    = (state == DONE) && out_free;
    upd.all   = !fin.hit;
    upd.rank  = fin.hit_rank;
    upd.wr    = !fin.hit;
    if (fin.hit) begin
      upd.slot  = fin.hit_idx;
      upd.limit = req.active;
    end else if (is_fill) begin
      upd.slot  = SLOT_BITS'(filled);
      upd.limit = CNT_BITS'(filled + 1'b1);
    end else begin
      upd.slot  = fin.vict_idx;
      upd.limit = req.nf;
    end
    if (fin.hit || (faults == FAULT_MAX)) begin
      faults_next = faults;
    end else begin
      faults_next = faults + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= NUM_FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_frames <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      scan_cnt      <= '0;
      req           <= '0;
      filled        <= '0;
      faults        <= '0;
      out_valid     <= 1'b0;
      hit           <= 1'b0;
      frame_slot    <= '0;
      evicted_valid <= 1'b0;
      evicted_page  <= '0;
      fault_count   <= '0;
    end else begin
      // DONE reloads the result register itself when it is free
      if (out_valid && out_ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            req.page   <= page;
            req.nf     <= nf_eff;
            req.active <= active_eff;
            scan_cnt   <= '0;
            state      <= SCAN;
          end
        end
        SCAN: begin
          if (scan_cnt == CNT_LAST) begin
            state <= DONE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            hit           <= fin.hit;
            frame_slot    <= upd.slot;
            evicted_valid <= !fin.hit && !is_fill;
            evicted_page  <= (!fin.hit && !is_fill) ? fin.vict_tag : '0;
            fault_count   <= faults_next;
            faults        <= faults_next;
            if (is_fill) begin
              filled <= filled + 1'b1;
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/lrupr_cell.sv */
// One frame of the LRU table: page tag, age rank and one stage of the lookup chain.
// Record and control types come from the top level as type parameters.
module lrupr_cell #(
  parameter int  INDEX      = 0,
  parameter int  MAX_FRAMES = 8,
  parameter int  PAGE_BITS  = 16,
  parameter type req_t      = logic,
  parameter type upd_t      = logic,
  parameter type scan_t     = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  req_t  req,
  input  upd_t  upd,
  input  scan_t scan_in,
  output scan_t scan_out
);

  localparam int SLOT_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_BITS  = $clog2(MAX_FRAMES + 1);
  localparam logic [SLOT_BITS-1:0] IDX_SLOT = SLOT_BITS'(INDEX);
  localparam logic [CNT_BITS-1:0]  IDX_CNT  = CNT_BITS'(INDEX);
  localparam logic [SLOT_BITS-1:0] RANK_MAX = SLOT_BITS'(MAX_FRAMES - 1);

  logic [PAGE_BITS-1:0] tag;
  logic [SLOT_BITS-1:0] rank;
  logic                 in_active;
  logic                 in_set;
  scan_t                scan_next;

  assign in_active = IDX_CNT < req.active;
  assign in_set    = IDX_CNT < req.nf;

  // Lowest matching frame wins; victim is the oldest, lowest index among equals.
  always_comb begin
    scan_next = scan_in;
    if (!scan_in.hit && in_active && (tag == req.page)) begin
      scan_next.hit      = 1'b1;
      scan_next.hit_idx  = IDX_SLOT;
      scan_next.hit_rank = rank;
    end
    if (in_set && ((INDEX == 0) || (rank > scan_in.vict_rank))) begin
      scan_next.vict_idx  = IDX_SLOT;
      scan_next.vict_rank = rank;
      scan_next.vict_tag  = tag;
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
    if (upd.en && (upd.slot == IDX_SLOT) && upd.wr) begin
      tag <= req.page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= '0;
    end else if (upd.en) begin
      if (upd.slot == IDX_SLOT) begin
        rank <= '0;
      end else if ((IDX_CNT < upd.limit) && (upd.all || (rank < upd.rank))
                   && (rank != RANK_MAX)) begin
        rank <= rank + 1'b1;
      end
    end
  end

endmodule

/* rtl/core/lrupr_checker.sv */
// Port-level checks for lru_page_replacement, attached by bind.
// Uses lrupr_pkg for the fault counter width.
module lrupr_checker
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16,
  localparam int SLOT_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  hit,
  input logic [SLOT_BITS-1:0]  frame_slot,
  input logic                  evicted_valid,
  input logic [PAGE_BITS-1:0]  evicted_page,
  input logic [FAULT_BITS-1:0] fault_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_slot) && $stable(fault_count))
    else $error("result changed while stalled");

  a_no_evict_page: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == '0)
    else $error("evicted page nonzero without eviction");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !evicted_valid)
    else $error("eviction reported on a hit");

  a_fault_seen: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> fault_count != '0)
    else $error("miss with zero fault count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken during lookup");

endmodule

bind lru_page_replacement lrupr_checker #(
  .MAX_FRAMES (MAX_FRAMES),
  .PAGE_BITS  (PAGE_BITS)
) u_lrupr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .hit           (hit),
  .frame_slot    (frame_slot),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page),
  .fault_count   (fault_count)
);
